// ----- src/framed_command_receiver_top_macros.svh -----
// Assertion macros for the framed command receiver.
// Used by framed_command_receiver_top; needs clk and rst_n in scope.
`ifndef FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH

// Checked while out of reset.
`define FCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define FCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- src/fcr_pkg.sv -----
// Shared types and constants for the framed command receiver.
// No dependencies.
`timescale 1ns / 1ps

package fcr_pkg;

  // Only positions 0..7 of the frame are ever inspected or reported.
  localparam int VIS_DEPTH = 8;
  localparam int VIS_IDX_W = $clog2(VIS_DEPTH);
  localparam int NUM_PAYLOAD = 5;
  localparam int PAYLOAD_BASE = 2;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_NONE    = 2'd0;
  localparam cmd_t CMD_BUTTONS = 2'd1;
  localparam cmd_t CMD_SOUND   = 2'd2;

  localparam logic [7:0] CH_LT   = 8'h3C; // '<'
  localparam logic [7:0] CH_GT   = 8'h3E; // '>'
  localparam logic [7:0] CH_P    = 8'h70; // 'p'
  localparam logic [7:0] CH_R    = 8'h72; // 'r'
  localparam logic [7:0] CH_O    = 8'h6F; // 'o'
  localparam logic [7:0] CH_G    = 8'h67; // 'g'
  localparam logic [7:0] CH_Y    = 8'h59; // 'Y'
  localparam logic [7:0] CH_N    = 8'h4E; // 'N'
  localparam logic [7:0] CH_ZERO = 8'h30; // '0'
  localparam logic [7:0] CH_ONE  = 8'h31; // '1'
  localparam logic [7:0] CH_TWO  = 8'h32; // '2'

  typedef struct packed {
    logic [4:0]                 fill_count;
    logic [NUM_PAYLOAD-1:0][7:0] payload;
    cmd_t                       command;
    logic                       prog_mode;
  } result_t;

endpackage

// ----- src/fcr_frame_core.sv -----
// Frame buffer, fill count, mode flag and held command with their update logic.
// Depends on fcr_pkg.
`timescale 1ns / 1ps

module fcr_frame_core #(
  parameter int FRAME_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             op,
  input  logic [7:0]       rx_byte,
  output fcr_pkg::result_t result
);
  import fcr_pkg::*;

  localparam int PW = $clog2(FRAME_DEPTH + 1);
  localparam int PEXT_W = PW + 5;

  logic [7:0]    fbuf_r   [VIS_DEPTH];
  logic [7:0]    fbuf_nxt [VIS_DEPTH];
  logic [7:0]    fbuf_pre [VIS_DEPTH];
  logic [PW-1:0] pos_r, pos_nxt, pos_a;
  logic          mode_r, mode_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic          is_start, mode_y, mode_n, mode_body;
  logic [PEXT_W-1:0] pos_ext;

  always_comb begin
    is_start = (rx_byte == CH_LT);
    // start marker: restart count, wipe everything past position 0
    for (int i = 0; i < VIS_DEPTH; i++) begin
      fbuf_pre[i] = (is_start && i != 0) ? 8'h00 : fbuf_r[i];
    end
    pos_a = is_start ? '0 : pos_r;

    fbuf_nxt  = fbuf_pre;
    pos_nxt   = pos_r;
    mode_nxt  = mode_r;
    cmd_nxt   = cmd_r;
    mode_body = 1'b0;
    mode_y    = 1'b0;
    mode_n    = 1'b0;

    if (op == OP_CLEAR) begin
      for (int i = 0; i < VIS_DEPTH; i++) fbuf_nxt[i] = 8'h00;
      cmd_nxt = CMD_NONE;
    end else begin
      if (pos_a < PW'(FRAME_DEPTH)) begin
        // positions beyond the inspected window are never read back
        if (pos_a < PW'(VIS_DEPTH)) fbuf_nxt[pos_a[VIS_IDX_W-1:0]] = rx_byte;
        pos_nxt = pos_a + PW'(1);
      end else begin
        // overflow: drop the byte and flush the frame
        for (int i = 0; i < VIS_DEPTH; i++) fbuf_nxt[i] = 8'h00;
        pos_nxt = '0;
      end

      mode_body = fbuf_nxt[0] == CH_LT && fbuf_nxt[1] == CH_P && fbuf_nxt[2] == CH_R &&
                  fbuf_nxt[3] == CH_O  && fbuf_nxt[4] == CH_G && fbuf_nxt[5] == CH_R &&
                  fbuf_nxt[7] == CH_GT;
      mode_y = mode_body && fbuf_nxt[6] == CH_Y;
      mode_n = mode_body && fbuf_nxt[6] == CH_N;
      if (mode_y) mode_nxt = 1'b1;
      else if (mode_n) mode_nxt = 1'b0;

      if (fbuf_nxt[0] == CH_LT) begin
        if (fbuf_nxt[1] == CH_ZERO && fbuf_nxt[2] == CH_ZERO &&
            fbuf_nxt[3] == CH_ZERO && fbuf_nxt[4] == CH_GT) begin
          cmd_nxt = CMD_NONE;
        end else if (fbuf_nxt[1] == CH_ONE && fbuf_nxt[7] == CH_GT) begin
          cmd_nxt = CMD_BUTTONS;
        end else if (fbuf_nxt[1] == CH_TWO && fbuf_nxt[3] == CH_GT) begin
          cmd_nxt = CMD_SOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VIS_DEPTH; i++) fbuf_r[i] <= 8'h00;
      pos_r  <= '0;
      mode_r <= 1'b0;
      cmd_r  <= CMD_NONE;
    end else if (en) begin
      fbuf_r <= fbuf_nxt;
      pos_r  <= pos_nxt;
      mode_r <= mode_nxt;
      cmd_r  <= cmd_nxt;
    end
  end

  // results show the state after the item being applied
  assign pos_ext = PEXT_W'(pos_nxt);
  always_comb begin
    result.prog_mode  = mode_nxt;
    result.command    = cmd_nxt;
    result.fill_count = pos_ext[4:0];
    for (int j = 0; j < NUM_PAYLOAD; j++) result.payload[j] = fbuf_nxt[PAYLOAD_BASE + j];
  end

endmodule

// ----- src/framed_command_receiver_top.sv -----
// Top level of the framed command receiver: stream ports, input and result registers.
// Depends on fcr_pkg, fcr_frame_core and framed_command_receiver_top_macros.svh.
`timescale 1ns / 1ps
`include "framed_command_receiver_top_macros.svh"

// Framed command receiver. Each input word is either a received character
// (in_tuser = 0) or a clear request (in_tuser = 1). A '<' starts a new frame;
// a character arriving on a full frame is dropped and the frame is flushed.
// The frames "<progrY>" and "<progrN>" set and clear the programming-mode flag,
// and "<000>", "<1.....>" and "<2.>" select the held command (none, set buttons,
// set sound); any other frame keeps the previous command. A clear request wipes
// the frame and the command but keeps the fill count and the mode flag.
// Every input word yields exactly one output word showing the state after it.
// Throughput is one word per clock while the output is not stalled; each word passes the
// input register, then the frame update feeding the result register. The result register stalls
// with out_tready, and one more word is still taken into the input register.
module framed_command_receiver_top #(
  parameter int FRAME_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] op: 0 byte, 1 clear
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [0] prog_mode, [2:1] command, [10:3] payload_0,
                                  // [18:11] payload_1, [26:19] payload_2,
                                  // [34:27] payload_3, [42:35] payload_4,
                                  // [47:43] fill_count
);
  import fcr_pkg::*;

  logic       s1_valid_r;
  logic       s1_op_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_data_r;
  result_t    core_result;
  logic       advance;
  logic       core_en;

  // result register free, or being drained this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign core_en   = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  fcr_frame_core #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (core_en),
    .op     (s1_op_r),
    .rx_byte(s1_byte_r),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) out_data_r <= core_result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FCR_ASSERT(a_cmd_legal, out_valid_r |-> (out_data_r.command != 2'd3), "illegal command code")
  `FCR_ASSERT(a_s1_hold, (s1_valid_r && !advance) |=> s1_valid_r, "staged word lost on stall")
  `FCR_ASSERT(a_clear_result, (core_en && s1_op_r == OP_CLEAR) |=> (out_valid_r && out_data_r.command == CMD_NONE && out_data_r.payload == '0), "clear did not wipe frame and command")
  `FCR_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!out_valid_r && !s1_valid_r), "pipeline not empty after reset")

endmodule
